// ===== src/sam_pkg.sv =====
// Shared types and constants for the sensor alarm monitor.
`default_nettype none

package sam_pkg;

  // Channel count and channel codes.
  localparam int unsigned NumChannels = 3;
  localparam logic [1:0] ChMethane  = 2'd0;
  localparam logic [1:0] ChMonoxide = 2'd1;
  localparam logic [1:0] ChAirflow  = 2'd2;

  // Limit register format and legal write range (0 < limit < 100.0 in Q8.8).
  localparam int unsigned LimitWidth = 15;
  localparam logic [LimitWidth-1:0] LimitMin = 15'd1;
  localparam logic [LimitWidth-1:0] LimitMax = 15'd25599;

  // Limit reset values: 80.0, 80.0 and 20.0 in Q8.8.
  localparam logic [LimitWidth-1:0] LimitMethaneRst  = 15'd20480;
  localparam logic [LimitWidth-1:0] LimitMonoxideRst = 15'd20480;
  localparam logic [LimitWidth-1:0] LimitAirflowRst  = 15'd5120;

  // Configuration register indexes.
  localparam logic [1:0] RegLimitMethane  = 2'd0;
  localparam logic [1:0] RegLimitMonoxide = 2'd1;
  localparam logic [1:0] RegLimitAirflow  = 2'd2;

  // Request kinds.
  localparam logic ReqDeadline = 1'b0;
  localparam logic ReqReading  = 1'b1;

  // Sensor status codes.
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatNoData = 2'd1;
  localparam logic [1:0] StatError  = 2'd2;

  typedef enum logic [2:0] {
    EvOk          = 3'd0,
    EvMissed      = 3'd1,
    EvStale       = 3'd2,
    EvSingleErr   = 3'd3,
    EvDoubleErr   = 3'd4,
    EvMonitorLate = 3'd5
  } status_ev_e;

  typedef enum logic [1:0] {
    LimNone  = 2'd0,
    LimEnter = 2'd1,
    LimLeave = 2'd2
  } limit_ev_e;

  // Input word: one request.
  typedef struct packed {
    logic        req_type;
    logic [1:0]  channel;
    logic [1:0]  sensor_status;
    logic [15:0] sample;
  } sam_req_t;

  // Output word: one result.
  typedef struct packed {
    logic [2:0]  alarm_mask;
    logic [1:0]  channel_out;
    logic [15:0] stored_sample;
    status_ev_e  status_event;
    limit_ev_e   limit_event;
  } sam_res_t;

endpackage

`default_nettype wire

// ===== src/sam_req_if.sv =====
// Valid/ready channel that carries request words into the monitor.
`default_nettype none

interface sam_req_if import sam_pkg::*; ();
  logic     valid;
  logic     ready;
  sam_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sam_res_if.sv =====
// Valid/ready channel that carries result words out of the monitor.
`default_nettype none

interface sam_res_if import sam_pkg::*; ();
  logic     valid;
  logic     ready;
  sam_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sensor_alarm_monitor_top.sv =====
// Top level of the three-channel sensor alarm monitor.
`default_nettype none

// Sensor alarm monitor. Each request word is either a sensor reading for one
// of three channels (methane, monoxide, air flow) or a notice that the
// monitor missed its deadline, and each request produces exactly one result
// word with the alarm mask, the stored Q8.8 sample of the addressed channel,
// a status event and a limit-crossing event. An accepted request's result is
// loaded into the output register and appears there on the next cycle; a new
// request is accepted every cycle as long as the output register is empty or
// being drained, so sustained throughput is one word per clock. Limits are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; writes outside 1..25599
// are ignored, and writes should only be made while the block is idle.
module sensor_alarm_monitor_top import sam_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [LimitWidth-1:0] cfg_data_i,
  sam_req_if.sink                    req_i,
  sam_res_if.source                  res_o
);

  // Channel state.
  logic [NumChannels-1:0] alarm_q, alarm_d;
  logic [NumChannels-1:0] missed_q, missed_d;
  logic [NumChannels-1:0] error_q, error_d;
  logic [NumChannels-1:0] viol_q, viol_d;
  logic [15:0]            last_q [NumChannels];
  logic [15:0]            last_d [NumChannels];

  // Limit registers.
  logic [LimitWidth-1:0] lim_meth_q, lim_mono_q, lim_air_q;

  // Output register.
  logic     out_valid_q;
  sam_res_t out_q, res_d;

  logic req_fire;
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  // Limit register writes, range-checked.
  logic cfg_ok;
  assign cfg_ok = (cfg_data_i >= LimitMin) && (cfg_data_i <= LimitMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_meth_q <= LimitMethaneRst;
      lim_mono_q <= LimitMonoxideRst;
      lim_air_q  <= LimitAirflowRst;
    end else if (cfg_we_i && cfg_ok) begin
      unique case (cfg_idx_i)
        RegLimitMethane:  lim_meth_q <= cfg_data_i;
        RegLimitMonoxide: lim_mono_q <= cfg_data_i;
        RegLimitAirflow:  lim_air_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-request evaluation: status handling, then the limit compare.
  logic [1:0]            ch;
  logic [LimitWidth-1:0] lim;
  logic [15:0]           smp;
  logic                  checked;
  logic                  viol;

  assign ch  = req_i.data.channel;
  assign smp = req_i.data.sample;

  always_comb begin
    unique case (ch)
      ChMethane:  lim = lim_meth_q;
      ChMonoxide: lim = lim_mono_q;
      default:    lim = lim_air_q;
    endcase
  end

  assign viol = (ch == ChAirflow) ? (smp < {1'b0, lim}) : (smp > {1'b0, lim});

  always_comb begin
    alarm_d  = alarm_q;
    missed_d = missed_q;
    error_d  = error_q;
    viol_d   = viol_q;
    last_d   = last_q;
    checked  = 1'b0;
    res_d.alarm_mask    = alarm_q;
    res_d.channel_out   = ChMethane;
    res_d.stored_sample = last_q[0];
    res_d.status_event  = EvOk;
    res_d.limit_event   = LimNone;

    if (req_i.data.req_type == ReqDeadline) begin
      // Monitor was late: raise every alarm.
      alarm_d             = '1;
      res_d.status_event  = EvMonitorLate;
    end else if (ch == 2'd3) begin
      // Unknown channel: no state change; the result carries only the alarm mask.
      res_d.stored_sample = '0;
    end else begin
      checked = 1'b1;
      if (req_i.data.sensor_status == StatNoData) begin
        alarm_d[ch]        = 1'b1;
        missed_d[ch]       = 1'b1;
        res_d.status_event = EvMissed;
        checked            = 1'b0;
      end else if (missed_q[ch]) begin
        alarm_d[ch]        = 1'b0;
        missed_d[ch]       = 1'b0;
        res_d.status_event = EvStale;
        checked            = 1'b0;
      end else if (req_i.data.sensor_status == StatOk) begin
        alarm_d[ch]        = 1'b0;
        error_d[ch]        = 1'b0;
        res_d.status_event = EvOk;
      end else if (error_q[ch]) begin
        alarm_d[ch]        = 1'b1;
        res_d.status_event = EvDoubleErr;
        checked            = 1'b0;
      end else begin
        error_d[ch]        = 1'b1;
        res_d.status_event = EvSingleErr;
      end

      if (checked) begin
        last_d[ch]  = smp;
        alarm_d[ch] = viol;
        viol_d[ch]  = viol;
        if (viol && !viol_q[ch]) begin
          res_d.limit_event = LimEnter;
        end else if (!viol && viol_q[ch]) begin
          res_d.limit_event = LimLeave;
        end
      end

      res_d.channel_out   = ch;
      res_d.stored_sample = last_d[ch];
    end
    res_d.alarm_mask = alarm_d;
  end

  // State and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q     <= '0;
      missed_q    <= '0;
      error_q     <= '0;
      viol_q      <= '0;
      last_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        alarm_q  <= alarm_d;
        missed_q <= missed_d;
        error_q  <= error_d;
        viol_q   <= viol_d;
        last_q   <= last_d;
      end
      if (req_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // A channel that is waiting for a fresh sample always has its alarm raised.
  a_missed_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (missed_q & ~alarm_q) == '0)
    else $error("missed channel without alarm");

  // Limit registers never leave the legal range.
  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim_meth_q >= LimitMin && lim_meth_q <= LimitMax &&
    lim_mono_q >= LimitMin && lim_mono_q <= LimitMax &&
    lim_air_q >= LimitMin && lim_air_q <= LimitMax)
    else $error("limit register out of range");

  // A late-monitor result reports all alarms on channel zero.
  a_late_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.status_event == EvMonitorLate |->
      res_o.data.alarm_mask == '1 && res_o.data.channel_out == ChMethane)
    else $error("late-monitor result malformed");

  // A limit crossing is reported only when the sample was compared.
  a_limit_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.limit_event != LimNone |->
      res_o.data.status_event == EvOk || res_o.data.status_event == EvSingleErr)
    else $error("limit event without compare");

  // The accepted word's result is loaded into the output register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> res_o.valid)
    else $error("result not presented after accept");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the sensor alarm monitor top level.
`default_nettype none

module testbench import sam_pkg::*; ();

  localparam int ReqBits = $bits(sam_req_t);

  // Tracks the monitor state, predicts every result word and checks it.
  class alarm_tracker;
    logic [LimitWidth-1:0] limits [NumChannels];
    bit                    alarm [NumChannels];
    bit                    missed [NumChannels];
    bit                    erred [NumChannels];
    bit                    violated [NumChannels];
    logic [15:0]           last_sample [NumChannels];
    sam_res_t              expected_q [$];
    int unsigned           errors;

    function new();
      errors = 0;
      limits[ChMethane]  = LimitMethaneRst;
      limits[ChMonoxide] = LimitMonoxideRst;
      limits[ChAirflow]  = LimitAirflowRst;
      for (int c = 0; c < NumChannels; c++) begin
        alarm[c]       = 1'b0;
        missed[c]      = 1'b0;
        erred[c]       = 1'b0;
        violated[c]    = 1'b0;
        last_sample[c] = '0;
      end
    endfunction

    // Out-of-range values and unknown indexes leave the limits alone.
    function void apply_limit(logic [1:0] idx, logic [LimitWidth-1:0] val);
      if (val < LimitMin || val > LimitMax) return;
      case (idx)
        RegLimitMethane:  limits[ChMethane]  = val;
        RegLimitMonoxide: limits[ChMonoxide] = val;
        RegLimitAirflow:  limits[ChAirflow]  = val;
        default: ;
      endcase
    endfunction

    function logic [LimitWidth-1:0] limit_of(int ch);
      return limits[ch];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [2:0] alarm_mask();
      return {alarm[2], alarm[1], alarm[0]};
    endfunction

    // Update the state for one accepted request and queue its result.
    function void note_request(sam_req_t r);
      sam_res_t res;
      int       ch;
      bit       checked;
      bit       over;
      res.channel_out   = '0;
      res.stored_sample = '0;
      res.status_event  = EvOk;
      res.limit_event   = LimNone;
      if (r.req_type == ReqDeadline) begin
        for (int c = 0; c < NumChannels; c++) alarm[c] = 1'b1;
        res.stored_sample = last_sample[ChMethane];
        res.status_event  = EvMonitorLate;
      end else if (r.channel > ChAirflow) begin
        // Unknown channel: nothing changes.
      end else begin
        ch = r.channel;
        checked = 1'b1;
        if (r.sensor_status == StatNoData) begin
          alarm[ch] = 1'b1;
          missed[ch] = 1'b1;
          res.status_event = EvMissed;
          checked = 1'b0;
        end else if (missed[ch]) begin
          alarm[ch] = 1'b0;
          missed[ch] = 1'b0;
          res.status_event = EvStale;
          checked = 1'b0;
        end else if (r.sensor_status == StatOk) begin
          alarm[ch] = 1'b0;
          erred[ch] = 1'b0;
        end else if (erred[ch]) begin
          alarm[ch] = 1'b1;
          res.status_event = EvDoubleErr;
          checked = 1'b0;
        end else begin
          erred[ch] = 1'b1;
          res.status_event = EvSingleErr;
        end
        if (checked) begin
          last_sample[ch] = r.sample;
          if (ch == ChAirflow) over = r.sample < {1'b0, limits[ch]};
          else over = r.sample > {1'b0, limits[ch]};
          if (over && !violated[ch]) res.limit_event = LimEnter;
          if (!over && violated[ch]) res.limit_event = LimLeave;
          alarm[ch] = over;
          violated[ch] = over;
        end
        res.channel_out   = r.channel;
        res.stored_sample = last_sample[ch];
      end
      res.alarm_mask = alarm_mask();
      expected_q = {expected_q, res};
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    // Compare one result word with the oldest prediction.
    task check_result(sam_res_t got);
      sam_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.alarm_mask !== want.alarm_mask)
        report_mismatch($sformatf("alarm_mask got %0d expected %0d",
                                  got.alarm_mask, want.alarm_mask));
      if (got.channel_out !== want.channel_out)
        report_mismatch($sformatf("channel_out got %0d expected %0d",
                                  got.channel_out, want.channel_out));
      if (got.stored_sample !== want.stored_sample)
        report_mismatch($sformatf("stored_sample got %0d expected %0d",
                                  got.stored_sample, want.stored_sample));
      if (got.status_event !== want.status_event)
        report_mismatch($sformatf("status_event got %0d expected %0d",
                                  got.status_event, want.status_event));
      if (got.limit_event !== want.limit_event)
        report_mismatch($sformatf("limit_event got %0d expected %0d",
                                  got.limit_event, want.limit_event));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;
  logic [LimitWidth-1:0] cfg_data;

  sam_req_if req_if ();
  sam_res_if res_if ();

  alarm_tracker board = new();

  int rx_mode;
  int rx_left;
  int rx_hold;

  sensor_alarm_monitor_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("FAIL sensor_alarm_monitor_top");
    $finish;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) board.note_request(req_if.data);
      if (res_if.valid && res_if.ready) board.check_result(res_if.data);
    end
  end

  // Result receiver: switches between stall patterns at random.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
      rx_hold = 0;
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= $urandom_range(0, 1);
      2: begin
        rx_hold = (rx_hold + 1) % 3;
        res_if.ready <= (rx_hold == 0);
      end
      default: begin
        // Long stalls with short open windows.
        if (rx_hold == 0) rx_hold = $urandom_range(1, 12);
        rx_hold--;
        res_if.ready <= (rx_hold < 3);
      end
    endcase
  end

  function automatic sam_req_t reading(logic [1:0] ch, logic [1:0] st, logic [15:0] smp);
    sam_req_t r;
    r.req_type      = ReqReading;
    r.channel       = ch;
    r.sensor_status = st;
    r.sample        = smp;
    return r;
  endfunction

  function automatic sam_req_t deadline_notice();
    sam_req_t r;
    r = ReqBits'($urandom);
    r.req_type = ReqDeadline;
    return r;
  endfunction

  // Mostly well-formed readings, with samples clustered around the limits.
  function automatic sam_req_t random_request();
    sam_req_t    r;
    int          pick;
    int          near;
    logic [15:0] lim;
    if ($urandom_range(0, 99) < 4) return deadline_notice();
    r.req_type = ReqReading;
    r.channel = ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 55) r.sensor_status = StatOk;
    else if (pick < 70) r.sensor_status = StatNoData;
    else if (pick < 90) r.sensor_status = StatError;
    else r.sensor_status = 2'd3;
    pick = $urandom_range(0, 9);
    if (pick < 4 && r.channel <= ChAirflow) begin
      lim = {1'b0, board.limit_of(r.channel)};
      near = int'(lim) + int'($urandom_range(0, 8)) - 4;
      if (near < 0) near = 0;
      r.sample = 16'(near);
    end else if (pick < 8) begin
      r.sample = 16'($urandom);
    end else begin
      r.sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return r;
  endfunction

  // Present one word and hold it until it is taken.
  task automatic send_word(sam_req_t w);
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    req_if.valid <= 1'b0;
    req_if.data  <= ReqBits'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [LimitWidth-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    board.apply_limit(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_limits(logic [LimitWidth-1:0] lm, logic [LimitWidth-1:0] lo,
                             logic [LimitWidth-1:0] la);
    write_limit(RegLimitMethane, lm);
    write_limit(RegLimitMonoxide, lo);
    write_limit(RegLimitAirflow, la);
  endtask

  // Random traffic in bursts; ignored channel-3 readings do not count.
  task automatic run_random(int count);
    int       left;
    int       burst;
    sam_req_t w;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        w = random_request();
        send_word(w);
        if (w.req_type == ReqDeadline || w.channel <= ChAirflow) left--;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      else if ($urandom_range(0, 49) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Directed checks with the reset limits.
  task automatic run_directed();
    // Extremes and limit equality on the upper-limit channel.
    send_word(reading(ChMethane, StatOk, 16'h0000));
    send_word(reading(ChMethane, StatOk, 16'hFFFF));
    send_word(reading(ChMethane, StatOk, 16'(LimitMethaneRst)));
    send_word(reading(ChMethane, StatOk, 16'(LimitMethaneRst) + 16'd1));
    // Lower-limit channel: below alarms, equal does not.
    send_word(reading(ChAirflow, StatOk, 16'(LimitAirflowRst) - 16'd1));
    send_word(reading(ChAirflow, StatOk, 16'(LimitAirflowRst)));
    // A single error is still checked, a second one in a row is not.
    send_word(reading(ChMonoxide, StatError, 16'hFFFF));
    send_word(reading(ChMonoxide, StatError, 16'h0000));
    send_word(reading(ChMonoxide, StatOk, 16'd100));
    // Status value 3 behaves as a sensor error.
    send_word(reading(ChMonoxide, 2'd3, 16'h5555));
    send_word(reading(ChMonoxide, 2'd3, 16'hAAAA));
    send_word(reading(ChMonoxide, StatOk, 16'd0));
    // Missing data, then the stale sample that follows it.
    send_word(reading(ChMethane, StatNoData, 16'h1234));
    send_word(reading(ChMethane, StatNoData, 16'h4321));
    send_word(reading(ChMethane, StatOk, 16'h0000));
    send_word(reading(ChMethane, StatOk, 16'h0010));
    // A miss takes precedence over a following error.
    send_word(reading(ChAirflow, StatNoData, 16'h0000));
    send_word(reading(ChAirflow, StatError, 16'hFFFF));
    // Readings for the unused channel are ignored.
    send_word(reading(2'd3, StatOk, 16'hAAAA));
    send_word(reading(2'd3, StatNoData, 16'h5555));
    // Deadline notices set every alarm regardless of their other fields.
    send_word(deadline_notice());
    send_word(reading(ChMethane, StatOk, 16'd5));
    idle_gap(2);
    send_word('0);
    send_word(reading(ChAirflow, 2'd3, 16'hFFFF));
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegLimitMethane;
    cfg_data      = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    res_if.ready  = 1'b0;
    rx_mode       = 0;
    rx_left       = 0;
    rx_hold       = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    // Tightest upper limits, tightest lower limit.
    load_limits(LimitMin, LimitMin, LimitMax);
    run_random(140);

    // Loosest upper limits, loosest lower limit, then ignored writes.
    load_limits(LimitMax, LimitMax, LimitMin);
    write_limit(RegLimitMethane, '0);
    write_limit(RegLimitMonoxide, LimitMax + 15'd1);
    write_limit(RegLimitAirflow, 15'h7FFF);
    write_limit(2'd3, 15'd300);
    run_random(140);

    // Random legal limits with one more ignored write.
    load_limits(LimitWidth'($urandom_range(LimitMin, LimitMax)),
                LimitWidth'($urandom_range(LimitMin, LimitMax)),
                LimitWidth'($urandom_range(LimitMin, LimitMax)));
    write_limit(RegLimitAirflow,
                LimitWidth'($urandom_range(int'(LimitMax) + 1, 32767)));
    run_random(140);

    repeat (5) @(negedge clk_i);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("PASS sensor_alarm_monitor_top");
    end else begin
      $display("FAIL sensor_alarm_monitor_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
